>>> hdl/dtbp_pkg.sv
// Shared types, constants and the base decoder for the two-bit DNA packer.
`timescale 1ns / 1ps

package dtbp_pkg;

    // Position store depth and derived widths
    localparam int MAX_OTHER_POSITIONS = 32;
    localparam int POS_AW = (MAX_OTHER_POSITIONS > 1) ? $clog2(MAX_OTHER_POSITIONS) : 1;
    localparam int CNT_W  = $clog2(MAX_OTHER_POSITIONS + 1);

    // Field widths
    localparam int WORD_W  = 32;
    localparam int BYTES_W = 3;
    localparam int CMD_W   = 2;

    // Byte counts carried with each result
    localparam logic [BYTES_W-1:0] BYTES_ONE  = 3'd1;
    localparam logic [BYTES_W-1:0] BYTES_WORD = 3'd4;

    // Trailer flag values
    localparam logic [7:0] FLAG_CLEAN = 8'h00;
    localparam logic [7:0] FLAG_OTHER = 8'hFF;

    // Base characters
    localparam logic [7:0] CH_A_UC = 8'h41;
    localparam logic [7:0] CH_C_UC = 8'h43;
    localparam logic [7:0] CH_G_UC = 8'h47;
    localparam logic [7:0] CH_T_UC = 8'h54;
    localparam logic [7:0] CH_A_LC = 8'h61;
    localparam logic [7:0] CH_C_LC = 8'h63;
    localparam logic [7:0] CH_G_LC = 8'h67;
    localparam logic [7:0] CH_T_LC = 8'h74;

    typedef enum logic [CMD_W-1:0] {
        CMD_BATCH = 2'd0,
        CMD_SEQ   = 2'd1,
        CMD_BASE  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLAG,
        ST_COUNT,
        ST_POS
    } t_state;

    // One result item
    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [BYTES_W-1:0] bytes;
        logic               last;
        logic               ovf;
    } t_result;

    // Write port of the position store
    typedef struct packed {
        logic              en;
        logic [POS_AW-1:0] addr;
        logic [WORD_W-1:0] data;
    } t_pos_wr;

    // Returns {other, code}: A/C/G/T in either case map to 0..3, anything else is other
    function automatic logic [2:0] base_code(input logic [WORD_W-1:0] ch);
        logic [2:0] res;
        res = 3'b100;
        case (ch)
            {24'd0, CH_A_UC}, {24'd0, CH_A_LC}: res = 3'b000;
            {24'd0, CH_C_UC}, {24'd0, CH_C_LC}: res = 3'b001;
            {24'd0, CH_G_UC}, {24'd0, CH_G_LC}: res = 3'b010;
            {24'd0, CH_T_UC}, {24'd0, CH_T_LC}: res = 3'b011;
            default:                            res = 3'b100;
        endcase
        return res;
    endfunction

endpackage

>>> hdl/dtbp_pos_ram.sv
// Position store: one write port, one registered read port.
`timescale 1ns / 1ps

module dtbp_pos_ram
    import dtbp_pkg::*;
(
    input  logic              i_clk,
    input  t_pos_wr           i_wr,
    input  logic [POS_AW-1:0] i_rd_addr,
    output logic [WORD_W-1:0] o_rd_data
);

    logic [WORD_W-1:0] mem [MAX_OTHER_POSITIONS];
    logic [WORD_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/dtbp_out_skid.sv
// Output register with a skid entry between the packer and the master stream.
`timescale 1ns / 1ps

module dtbp_out_skid
    import dtbp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_up_valid,
    output logic    o_up_ready,
    input  t_result i_up,
    output logic    o_dn_valid,
    input  logic    i_dn_ready,
    output t_result o_dn
);

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    up_take;
    logic    dn_take;

    assign o_up_ready = !r_skid_valid;
    assign up_take    = i_up_valid && o_up_ready;
    assign dn_take    = r_out_valid && i_dn_ready;

    // Move skid into the output slot first, otherwise take the new item
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || dn_take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = i_up;
                n_out_valid = up_take;
            end
        end else if (up_take) begin
            n_skid       = i_up;
            n_skid_valid = 1'b1;
        end
    end

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_dn_valid = r_out_valid;
    assign o_dn       = r_out;

    // Skid entry is only used behind a full output slot
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output slot");

    // A taken item always lands somewhere
    a_take_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && up_take) |=> r_out_valid)
        else $error("accepted item not held in output slot");

    // A full skid under stall keeps its item
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && r_skid_valid && !i_dn_ready) |=> r_skid_valid)
        else $error("skid entry lost under stall");

endmodule

>>> hdl/dtbp_read_ctrl.sv
// Read state, base packing, position store access and trailer sequencing.
`timescale 1ns / 1ps

module dtbp_read_ctrl
    import dtbp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [WORD_W-1:0] i_payload,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_result           o_res,
    output t_pos_wr           o_pos_wr,
    output logic [POS_AW-1:0] o_pos_rd_addr,
    input  logic [WORD_W-1:0] i_pos_rd_data
);

    t_state            r_state, n_state;
    logic [WORD_W-1:0] r_seq_len, n_seq_len;
    logic [WORD_W-1:0] r_base_idx, n_base_idx;
    logic [7:0]        r_pack, n_pack;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_ovf, n_ovf;
    logic [POS_AW-1:0] r_pos_idx, n_pos_idx;

    t_cmd              cmd;
    logic              accept;
    logic [2:0]        decoded;
    logic              is_other;
    logic [WORD_W-1:0] idx_inc;
    logic              base_live;
    logic              read_done;
    logic              emit_byte;
    logic [7:0]        pack_new;
    logic              store_full;
    logic              trailer_clean;
    logic              pos_last;

    assign cmd        = t_cmd'(i_cmd);
    assign o_in_ready = (r_state == ST_IDLE) && i_res_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Base decode and packing
    assign decoded    = base_code(i_payload);
    assign is_other   = decoded[2];
    assign base_live  = r_base_idx < r_seq_len;
    assign idx_inc    = r_base_idx + 32'd1;
    assign read_done  = idx_inc == r_seq_len;
    assign emit_byte  = (idx_inc[1:0] == 2'b00) || read_done;
    assign pack_new   = r_pack | (8'(decoded[1:0]) << {r_base_idx[1:0], 1'b0});
    assign store_full = r_cnt >= CNT_W'(MAX_OTHER_POSITIONS);

    // Trailer conditions
    assign trailer_clean = (r_cnt == '0) && !r_ovf;
    assign pos_last      = (CNT_W'(r_pos_idx) + CNT_W'(1)) == r_cnt;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && cmd == CMD_SEQ && i_payload == '0) begin
                    n_state = ST_FLAG;
                end else if (accept && cmd == CMD_BASE && base_live && read_done) begin
                    n_state = ST_FLAG;
                end
            end
            ST_FLAG: begin
                if (i_res_ready) begin
                    n_state = trailer_clean ? ST_IDLE : ST_COUNT;
                end
            end
            ST_COUNT: begin
                if (i_res_ready) begin
                    n_state = (r_cnt == '0) ? ST_IDLE : ST_POS;
                end
            end
            ST_POS: begin
                if (i_res_ready && pos_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Result outputs
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (cmd)
                        CMD_BATCH: begin
                            o_res_valid = 1'b1;
                            o_res.word  = i_payload;
                            o_res.bytes = BYTES_WORD;
                            o_res.last  = 1'b1;
                        end
                        CMD_SEQ: begin
                            o_res_valid = 1'b1;
                            o_res.word  = i_payload;
                            o_res.bytes = BYTES_WORD;
                            o_res.last  = i_payload != '0;
                        end
                        CMD_BASE: begin
                            o_res_valid = base_live && emit_byte;
                            o_res.word  = {24'd0, pack_new};
                            o_res.bytes = BYTES_ONE;
                            o_res.last  = !read_done;
                        end
                        CMD_NONE: o_res_valid = 1'b0;
                        default:  o_res_valid = 1'b0;
                    endcase
                end
            end
            ST_FLAG: begin
                o_res_valid = 1'b1;
                o_res.word  = {24'd0, trailer_clean ? FLAG_CLEAN : FLAG_OTHER};
                o_res.bytes = BYTES_ONE;
                o_res.last  = trailer_clean;
                o_res.ovf   = r_ovf;
            end
            ST_COUNT: begin
                o_res_valid = 1'b1;
                o_res.word  = WORD_W'(r_cnt);
                o_res.bytes = BYTES_WORD;
                o_res.last  = r_cnt == '0;
                o_res.ovf   = r_ovf;
            end
            ST_POS: begin
                o_res_valid = 1'b1;
                o_res.word  = i_pos_rd_data;
                o_res.bytes = BYTES_WORD;
                o_res.last  = pos_last;
                o_res.ovf   = r_ovf;
            end
            default: o_res_valid = 1'b0;
        endcase
    end

    // Read state update and position store write
    always_comb begin
        n_seq_len  = r_seq_len;
        n_base_idx = r_base_idx;
        n_pack     = r_pack;
        n_cnt      = r_cnt;
        n_ovf      = r_ovf;
        o_pos_wr   = '0;
        if (accept) begin
            unique case (cmd)
                CMD_BATCH, CMD_SEQ: begin
                    n_seq_len  = (cmd == CMD_SEQ) ? i_payload : '0;
                    n_base_idx = '0;
                    n_pack     = '0;
                    n_cnt      = '0;
                    n_ovf      = 1'b0;
                end
                CMD_BASE: begin
                    if (base_live) begin
                        n_base_idx = idx_inc;
                        n_pack     = emit_byte ? 8'd0 : pack_new;
                        if (is_other && !store_full) begin
                            o_pos_wr.en   = 1'b1;
                            o_pos_wr.addr = r_cnt[POS_AW-1:0];
                            o_pos_wr.data = r_base_idx;
                            n_cnt         = r_cnt + CNT_W'(1);
                        end else if (is_other) begin
                            n_ovf = 1'b1;
                        end
                    end
                end
                CMD_NONE: n_cnt = r_cnt;
                default:  n_cnt = r_cnt;
            endcase
        end
    end

    // Trailer read pointer; the store is read at the next index every cycle, so the
    // entry written by the last base is re-read before the position phase uses it
    always_comb begin
        n_pos_idx = r_pos_idx;
        if (r_state != ST_POS) begin
            n_pos_idx = '0;
        end else if (i_res_ready && !pos_last) begin
            n_pos_idx = r_pos_idx + POS_AW'(1);
        end
    end

    assign o_pos_rd_addr = n_pos_idx;

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_seq_len  <= '0;
            r_base_idx <= '0;
            r_pack     <= '0;
            r_cnt      <= '0;
            r_ovf      <= 1'b0;
            r_pos_idx  <= '0;
        end else begin
            r_state    <= n_state;
            r_seq_len  <= n_seq_len;
            r_base_idx <= n_base_idx;
            r_pack     <= n_pack;
            r_cnt      <= n_cnt;
            r_ovf      <= n_ovf;
            r_pos_idx  <= n_pos_idx;
        end
    end

    // Stored count never passes the store depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_OTHER_POSITIONS))
        else $error("position count beyond store depth");

    // A dropped position only happens with a full store
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_cnt == CNT_W'(MAX_OTHER_POSITIONS)))
        else $error("overflow set with room left in store");

    // Position phase only reads written entries
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POS) |-> (CNT_W'(r_pos_idx) < r_cnt))
        else $error("trailer reads beyond stored positions");

endmodule

>>> hdl/dna_two_bit_packer.sv
// Top level: streams DNA read batches into 2-bit packed records with N-position trailers.
// Results are registered in the output slot or skid entry before reaching the master side.
// Throughput: one item per cycle unless back-pressured; an item ending a read (last base,
// or zero-length sequence header) adds a trailer: a flag (clean read), or a flag, a count
// and n stored positions, holding off input; the single result path and the store's one
// read port set this. Reset: synchronous, active low; clears read state, not the store.
`timescale 1ns / 1ps

module dna_two_bit_packer
    import dtbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] payload
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] command
    // Master stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] out_word, [34:32] word_bytes, rest zero
    output logic        o_m_axis_tlast,   // last_of_run
    output logic        o_m_axis_tuser    // [0] overflow_flag
);

    logic              res_valid;
    logic              res_ready;
    t_result           res;
    t_result           dn;
    t_pos_wr           pos_wr;
    logic [POS_AW-1:0] pos_rd_addr;
    logic [WORD_W-1:0] pos_rd_data;

    // Control and packing
    dtbp_read_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_s_axis_tvalid),
        .o_in_ready    (o_s_axis_tready),
        .i_cmd         (i_s_axis_tuser),
        .i_payload     (i_s_axis_tdata),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res),
        .o_pos_wr      (pos_wr),
        .o_pos_rd_addr (pos_rd_addr),
        .i_pos_rd_data (pos_rd_data)
    );

    // N-position store
    dtbp_pos_ram u_pos_ram (
        .i_clk     (i_clk),
        .i_wr      (pos_wr),
        .i_rd_addr (pos_rd_addr),
        .o_rd_data (pos_rd_data)
    );

    // Output register and skid
    dtbp_out_skid u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (res_valid),
        .o_up_ready (res_ready),
        .i_up       (res),
        .o_dn_valid (o_m_axis_tvalid),
        .i_dn_ready (i_m_axis_tready),
        .o_dn       (dn)
    );

    // Master payload packing
    assign o_m_axis_tdata = {5'd0, dn.bytes, dn.word};
    assign o_m_axis_tlast = dn.last;
    assign o_m_axis_tuser = dn.ovf;

endmodule

>>> dv/tb_dna_two_bit_packer.sv
// Self-checking testbench for the two-bit DNA packer: directed and random read batches.
`timescale 1ns / 1ps

module tb_dna_two_bit_packer;
    import dtbp_pkg::*;

    localparam int IDLE_LIMIT   = 2000;   // cycles with no item moving on either side
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;    // long receiver hold-off, once per run
    localparam int HOLD_AFTER   = 80;     // input items accepted before the hold-off
    localparam int RANDOM_ITEMS = 230;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] payload;
    } t_stream_item;

    typedef enum logic [1:0] {
        RX_OPEN,     // always ready
        RX_COIN,     // ready half the time
        RX_SPARSE    // mostly stalled
    } t_rx_mode;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata  = '0;   // [31:0] payload
    logic [1:0]  i_s_axis_tuser  = '0;   // [1:0] command
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;         // [31:0] out_word, [34:32] word_bytes
    logic        o_m_axis_tlast;         // last_of_run
    logic        o_m_axis_tuser;         // [0] overflow_flag

    // Stimulus and expected records
    t_stream_item pending_items[$];
    t_result      expected_records[$];

    // Predictor state
    logic [31:0] read_len;
    logic [31:0] bases_done;
    logic [7:0]  byte_acc;
    int          n_count;
    logic [31:0] n_pos [MAX_OTHER_POSITIONS];
    logic        n_dropped;

    // Bench bookkeeping
    int mismatch_count  = 0;
    int records_checked = 0;
    int items_accepted  = 0;
    int idle_cycles     = 0;
    int stim_count      = 0;
    int burst_left      = 1;
    int gap_left        = 0;
    bit took_item       = 1'b0;

    dna_two_bit_packer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        $display("record %0d: %s expected 0x%0h got 0x%0h",
                 records_checked, what, want, got);
    endtask

    task automatic push_record(input logic [31:0] word, input logic [2:0] nbytes,
                               input logic ovf);
        t_result r;
        r.word  = word;
        r.bytes = nbytes;
        r.last  = 1'b0;
        r.ovf   = ovf;
        expected_records.insert(expected_records.size(), r);
    endtask

    // Read trailer: clean flag, or flag, N count and stored N positions
    task automatic push_trailer();
        if (n_count == 0 && !n_dropped) begin
            push_record({24'd0, FLAG_CLEAN}, BYTES_ONE, n_dropped);
        end else begin
            push_record({24'd0, FLAG_OTHER}, BYTES_ONE, n_dropped);
            push_record(32'(n_count), BYTES_WORD, n_dropped);
            for (int i = 0; i < n_count; i++)
                push_record(n_pos[i], BYTES_WORD, n_dropped);
        end
    endtask

    task automatic clear_read_state();
        bases_done = '0;
        byte_acc   = '0;
        n_count    = 0;
        n_dropped  = 1'b0;
    endtask

    // Works out the records one accepted input item produces
    task automatic pack_input_item(input t_cmd cmd, input logic [31:0] payload);
        int          first;
        logic [1:0]  code;
        bit          is_other;
        first = expected_records.size();
        case (cmd)
            CMD_BATCH: begin
                read_len = '0;
                clear_read_state();
                push_record(payload, BYTES_WORD, 1'b0);
            end
            CMD_SEQ: begin
                read_len = payload;
                clear_read_state();
                push_record(payload, BYTES_WORD, 1'b0);
                if (read_len == 0)
                    push_trailer();
            end
            CMD_BASE: begin
                if (bases_done < read_len) begin
                    is_other = 1'b0;
                    case (payload) inside
                        "A", "a": code = 2'd0;
                        "C", "c": code = 2'd1;
                        "G", "g": code = 2'd2;
                        "T", "t": code = 2'd3;
                        default: begin
                            code     = 2'd0;
                            is_other = 1'b1;
                        end
                    endcase
                    byte_acc = byte_acc | (8'(code) << (bases_done[1:0] * 2));
                    if (is_other) begin
                        if (n_count < MAX_OTHER_POSITIONS) begin
                            n_pos[n_count] = bases_done;
                            n_count++;
                        end else begin
                            n_dropped = 1'b1;
                        end
                    end
                    bases_done = bases_done + 1;
                    if (bases_done[1:0] == 2'd0 || bases_done == read_len) begin
                        push_record({24'd0, byte_acc}, BYTES_ONE, 1'b0);
                        byte_acc = '0;
                    end
                    if (bases_done == read_len)
                        push_trailer();
                end
            end
            default: ;
        endcase
        if (expected_records.size() > first)
            expected_records[expected_records.size() - 1].last = 1'b1;
    endtask

    // Stimulus helpers
    task automatic add_item(input t_cmd cmd, input logic [31:0] payload, input bit counted);
        t_stream_item it;
        it.cmd     = cmd;
        it.payload = payload;
        pending_items.insert(pending_items.size(), it);
        if (counted)
            stim_count++;
    endtask

    function automatic logic [31:0] pick_base(input int other_pct);
        logic [31:0] ch;
        if (int'($urandom_range(1, 100)) > other_pct) begin
            case ($urandom_range(0, 7))
                0: ch = "A";
                1: ch = "C";
                2: ch = "G";
                3: ch = "T";
                4: ch = "a";
                5: ch = "c";
                6: ch = "g";
                default: ch = "t";
            endcase
        end else begin
            case ($urandom_range(0, 3))
                0: ch = "N";
                1: ch = $urandom_range(0, 255);
                2: ch = $urandom;
                default: ch = 32'("A") | (32'd1 << $urandom_range(8, 31));
            endcase
        end
        return ch;
    endfunction

    task automatic add_read(input logic [31:0] len, input int other_pct);
        add_item(CMD_SEQ, len, 1'b1);
        for (int i = 0; i < int'(len); i++)
            add_item(CMD_BASE, pick_base(other_pct), 1'b1);
    endtask

    // Sender: bursts and gaps, an offered item is held until taken
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && !took_item) begin
                // keep offering the same item
            end else if (gap_left > 0) begin
                gap_left--;
                i_s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tuser  <= pending_items[0].cmd;
                i_s_axis_tdata  <= pending_items[0].payload;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern by mode, plus one long hold-off
    always @(negedge i_clk) begin
        static int       hold_left = 0;
        static bit       hold_done = 1'b0;
        static int       mode_left = 0;
        static t_rx_mode rx_mode   = RX_OPEN;
        if (!hold_done && items_accepted >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            case (rx_mode)
                RX_OPEN:   i_m_axis_tready <= 1'b1;
                RX_COIN:   i_m_axis_tready <= 1'($urandom_range(0, 1));
                default:   i_m_axis_tready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    // Input acceptance feeds the predictor; output records are checked in order
    always @(posedge i_clk) begin
        t_result      want;
        took_item = 1'b0;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            pack_input_item(t_cmd'(i_s_axis_tuser), i_s_axis_tdata);
            void'(pending_items.pop_front());
            took_item = 1'b1;
            items_accepted++;
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(1, 12);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_records.size() == 0) begin
                report_mismatch("unexpected record, word", '0, o_m_axis_tdata[31:0]);
            end else begin
                want = expected_records.pop_front();
                if (o_m_axis_tdata[31:0] !== want.word)
                    report_mismatch("out_word", want.word, o_m_axis_tdata[31:0]);
                if (o_m_axis_tdata[34:32] !== want.bytes)
                    report_mismatch("word_bytes", 32'(want.bytes),
                                    32'(o_m_axis_tdata[34:32]));
                if (o_m_axis_tlast !== want.last)
                    report_mismatch("last_of_run", 32'(want.last), 32'(o_m_axis_tlast));
                if (o_m_axis_tuser !== want.ovf)
                    report_mismatch("overflow_flag", 32'(want.ovf), 32'(o_m_axis_tuser));
            end
            records_checked++;
        end
    end

    // Watchdog on cycles where nothing moves
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_dna_two_bit_packer: FAIL");
            $finish;
        end
    end

    initial begin
        int          sel;
        logic [31:0] long_len;
        read_len = '0;
        clear_read_state();

        // Directed: header extremes, ignored items, clean and N reads, closed reads
        add_item(CMD_BATCH, 32'h0000_0000, 1'b1);
        add_item(CMD_BATCH, 32'hFFFF_FFFF, 1'b1);
        add_item(CMD_BASE, "A", 1'b0);              // no read open
        add_item(CMD_NONE, 32'h1234_5678, 1'b0);    // unused command
        add_item(CMD_SEQ, 32'd0, 1'b1);             // empty read
        add_item(CMD_SEQ, 32'd5, 1'b1);
        add_item(CMD_BASE, "a", 1'b1);
        add_item(CMD_BASE, "C", 1'b1);
        add_item(CMD_BASE, "g", 1'b1);
        add_item(CMD_BASE, "T", 1'b1);
        add_item(CMD_BASE, "N", 1'b1);
        add_item(CMD_SEQ, 32'd4, 1'b1);
        add_item(CMD_BASE, "t", 1'b1);
        add_item(CMD_BASE, 32'h0000_0141, 1'b1);    // wide payload is not a base
        add_item(CMD_BASE, 32'h0000_00FF, 1'b1);
        add_item(CMD_BASE, "c", 1'b1);
        add_item(CMD_SEQ, 32'hFFFF_FFFF, 1'b1);     // longest read, cut short
        add_item(CMD_BASE, "G", 1'b1);
        add_item(CMD_BASE, "x", 1'b1);
        add_item(CMD_BATCH, 32'd7, 1'b1);           // drops the open read
        add_item(CMD_BASE, "C", 1'b0);
        add_item(CMD_SEQ, 32'd1, 1'b1);
        add_item(CMD_BASE, "t", 1'b1);

        // Random: mostly whole reads, some overflow reads, cut reads and noise
        while (stim_count < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 58) begin
                add_read($urandom_range(1, 12), 10);
            end else if (sel < 63) begin
                add_read(32'd0, 0);
            end else if (sel < 68) begin
                add_read($urandom_range(33, 38), $urandom_range(85, 100));
            end else if (sel < 78) begin
                long_len = $urandom | 32'h0000_0100;
                add_item(CMD_SEQ, long_len, 1'b1);
                repeat ($urandom_range(0, 6))
                    add_item(CMD_BASE, pick_base(30), 1'b1);
                if ($urandom_range(0, 1) == 0)
                    add_item(CMD_BATCH, $urandom, 1'b1);
                else
                    add_read($urandom_range(1, 8), 20);
            end else if (sel < 88) begin
                add_item(CMD_BATCH, $urandom, 1'b1);
            end else if (sel < 94) begin
                add_item(CMD_BASE, pick_base(30), 1'b0);
            end else begin
                add_item(CMD_NONE, $urandom, 1'b0);
            end
        end

        // Hold reset, then release it
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || expected_records.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("tb_dna_two_bit_packer: PASS");
        else
            $display("tb_dna_two_bit_packer: FAIL");
        $finish;
    end

endmodule
